@@ hdl/part_pkg.sv @@
package part_pkg;

  localparam int RULE_SLOTS_DEF = 64;
  localparam int PATH_BYTES_DEF = 128;

  localparam int ACT_W    = 2;
  localparam int PID_W    = 64;
  localparam int MASK_W   = 32;
  localparam int CHUNK_W  = 64;
  localparam int TOTAL_W  = 7;

  typedef enum logic [ACT_W-1:0] {
    ACT_INIT  = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_CHECK = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

endpackage

@@ hdl/path_access_rule_table_unit.sv @@
// First-match access rule table. Init (one item) clears every rule and enables
// the table; add streams a path in 8-byte chunks, one item per cycle, and
// stores the rule in the lowest free slot on the item marked last; check
// streams the path in the same chunks, and clear removes the rules of one
// process id (id 0 removes all). A non-final add item is only taken in; init,
// clear of all rules and a final add item then pass through a finish state
// that loads the result. Each check item and a clear by id first sweep the
// single-read-port rule memories, one slot per cycle, each read registered
// before it is evaluated; a non-final check item then returns to idle, while a
// final check item and a clear by id pass through the finish state. A result
// waits in the finish state while the output register is still full. One
// result follows every init, clear and final add or check item; the output
// register holds it while the next item is already taken in.
module path_access_rule_table_unit #(
  parameter int RULE_SLOTS = part_pkg::RULE_SLOTS_DEF,
  parameter int PATH_BYTES = part_pkg::PATH_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [part_pkg::ACT_W-1:0]   in_action,
  input  logic [part_pkg::PID_W-1:0]   in_proc_id,
  input  logic [part_pkg::MASK_W-1:0]  in_access_bits,
  input  logic                         in_deny_flag,
  input  logic [part_pkg::CHUNK_W-1:0] in_path_chunk,
  input  logic                         in_chunk_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [part_pkg::ACT_W-1:0]   out_done_action,
  output logic                         out_status,
  output logic                         out_allowed,
  output logic [part_pkg::TOTAL_W-1:0] out_rule_total
);
  import part_pkg::*;

  localparam int PATH_WORDS = (PATH_BYTES + 7) / 8;
  localparam int SW   = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int SCW  = $clog2(RULE_SLOTS + 1);
  localparam int CIW  = $clog2(PATH_WORDS + 1);
  localparam int PAW  = $clog2(RULE_SLOTS * PATH_WORDS);
  localparam int META_W = PID_W + MASK_W + 1 + CIW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FIN
  } state_t;

  state_t                 state_r;
  logic [RULE_SLOTS-1:0]  valid_r;
  logic [RULE_SLOTS-1:0]  match_r;
  logic [SCW-1:0]         count_r;
  logic                   en_r;
  logic                   busy_r;
  logic [ACT_W-1:0]       busy_act_r;
  logic [CIW-1:0]         ci_r;
  logic                   ended_r;
  logic [SW-1:0]          slot_r;
  logic                   slot_ok_r;
  logic [CIW-1:0]         add_len_r;

  // latched item for the sweep
  logic [ACT_W-1:0]       act_r;
  logic [PID_W-1:0]       pid_r;
  logic [MASK_W-1:0]      acc_r;
  logic                   last_r;
  logic [CHUNK_W-1:0]     w_r;
  logic [CIW-1:0]         cmp_ci_r;
  logic                   cmp_en_r;
  logic                   found_r;
  logic                   allow_r;
  logic                   status_r;

  logic [SCW-1:0]         rd_idx_r;
  logic                   ev_v_r;
  logic [SW-1:0]          ev_idx_r;

  logic                   out_valid_r;
  logic [ACT_W-1:0]       out_act_r;
  logic                   out_status_r;
  logic                   out_allowed_r;
  logic [TOTAL_W-1:0]     out_total_r;

  logic [CHUNK_W-1:0]     path_mem [RULE_SLOTS*PATH_WORDS];
  logic [META_W-1:0]      meta_mem [RULE_SLOTS];
  logic [CHUNK_W-1:0]     path_q;
  logic [META_W-1:0]      meta_q;

  // accept-cycle logic
  logic                   acc;
  logic                   is_add;
  logic                   is_stream;
  logic                   start;
  logic [CIW-1:0]         ci_cur;
  logic                   ended_cur;
  logic                   ended_nxt;
  logic [CHUNK_W-1:0]     w_nxt;
  logic [SW-1:0]          pick;
  logic                   pick_ok;
  logic [SW-1:0]          slot_cur;
  logic                   slot_ok_cur;
  logic [CIW-1:0]         len_cur;
  logic                   word_en;
  logic [CIW-1:0]         ci_nxt;
  logic                   path_we;
  logic                   meta_we;

  assign acc       = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign is_add    = (in_action == ACT_ADD);
  assign is_stream = (in_action == ACT_ADD) || (in_action == ACT_CHECK);
  assign start     = !busy_r || (busy_act_r != in_action);
  assign ci_cur    = start ? '0 : ci_r;
  assign ended_cur = start ? 1'b0 : ended_r;
  assign word_en   = (int'(ci_cur) < PATH_WORDS);
  assign ci_nxt    = word_en ? ci_cur + CIW'(1) : ci_cur;

  always_comb begin
    int  pos;
    logic [7:0] byt;
    logic e;
    e = ended_cur;
    w_nxt = '0;
    for (int b = 0; b < 8; b++) begin
      pos = int'(ci_cur) * 8 + b;
      byt = in_path_chunk[8*b +: 8];
      if (e || pos >= PATH_BYTES) begin
        byt = '0;
      end else if (byt == 8'd0) begin
        e = 1'b1;
      end
      if (is_add && pos == PATH_BYTES - 1) begin
        byt = '0;
      end
      w_nxt[8*b +: 8] = byt;
    end
    ended_nxt = e;
  end

  // lowest free slot
  always_comb begin
    pick    = '0;
    pick_ok = 1'b0;
    for (int i = RULE_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        pick    = SW'(i);
        pick_ok = 1'b1;
      end
    end
  end

  assign slot_cur    = start ? pick : slot_r;
  assign slot_ok_cur = start ? (pick_ok && en_r) : slot_ok_r;
  assign len_cur     = (start ? '0 : add_len_r);
  assign path_we     = acc && is_add && slot_ok_cur && word_en;
  assign meta_we     = acc && is_add && slot_ok_cur && in_chunk_last;

  logic [CIW-1:0] len_fin;
  assign len_fin = (word_en && w_nxt != '0) ? ci_nxt : len_cur;

  always_ff @(posedge clk) begin
    if (path_we) begin
      path_mem[PAW'(int'(slot_cur) * PATH_WORDS + int'(ci_cur))] <= w_nxt;
    end
    if (meta_we) begin
      meta_mem[slot_cur] <= {in_proc_id, in_access_bits, in_deny_flag, len_fin};
    end
  end

  always_ff @(posedge clk) begin
    path_q <= path_mem[PAW'(int'(rd_idx_r[SW-1:0]) * PATH_WORDS + int'(cmp_ci_r))];
    meta_q <= meta_mem[rd_idx_r[SW-1:0]];
  end

  // evaluation of the slot read in the previous cycle
  logic [PID_W-1:0]  m_pid;
  logic [MASK_W-1:0] m_mask;
  logic              m_deny;
  logic [CIW-1:0]    m_len;
  logic [CHUNK_W-1:0] word_eff;
  logic              m_new;
  logic              hit;
  logic              clr_hit;

  assign {m_pid, m_mask, m_deny, m_len} = meta_q;
  assign word_eff = (cmp_ci_r < m_len) ? path_q : '0;
  assign m_new    = match_r[ev_idx_r] && (!cmp_en_r || word_eff == w_r);
  assign hit      = valid_r[ev_idx_r] && m_new && (m_pid == '0 || m_pid == pid_r) &&
                    (ci_r >= m_len) && ((m_mask & acc_r) != '0);
  assign clr_hit  = valid_r[ev_idx_r] && (m_pid == pid_r);

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      count_r     <= '0;
      en_r        <= 1'b0;
      busy_r      <= 1'b0;
      busy_act_r  <= '0;
      ci_r        <= '0;
      ended_r     <= 1'b0;
      slot_ok_r   <= 1'b0;
      add_len_r   <= '0;
      ev_v_r      <= 1'b0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (acc) begin
            act_r    <= in_action;
            pid_r    <= in_proc_id;
            acc_r    <= in_access_bits;
            last_r   <= in_chunk_last;
            status_r <= is_add && in_chunk_last && !slot_ok_cur;
            allow_r  <= (in_action == ACT_CHECK);
            found_r  <= 1'b0;
            if (!is_stream) begin
              busy_r <= 1'b0;
              if (in_action == ACT_INIT) begin
                valid_r <= '0;
                count_r <= '0;
                en_r    <= 1'b1;
                state_r <= ST_FIN;
              end else if (in_proc_id == '0) begin
                valid_r <= '0;
                count_r <= '0;
                state_r <= ST_FIN;
              end else begin
                rd_idx_r <= '0;
                cmp_en_r <= 1'b0;
                cmp_ci_r <= '0;
                state_r  <= ST_SWEEP;
              end
            end else begin
              busy_r     <= !in_chunk_last;
              busy_act_r <= in_action;
              ci_r       <= ci_nxt;
              ended_r    <= word_en ? ended_nxt : ended_cur;
              slot_r     <= slot_cur;
              slot_ok_r  <= slot_ok_cur;
              add_len_r  <= len_fin;
              if (is_add) begin
                if (in_chunk_last) begin
                  if (slot_ok_cur) begin
                    valid_r[slot_cur] <= 1'b1;
                    count_r <= count_r + SCW'(1);
                  end
                  state_r <= ST_FIN;
                end
              end else begin
                if (start) begin
                  match_r <= '1;
                end
                w_r      <= w_nxt;
                cmp_ci_r <= ci_cur;
                cmp_en_r <= word_en;
                rd_idx_r <= '0;
                state_r  <= ST_SWEEP;
              end
            end
          end
        end
        ST_SWEEP: begin
          if (int'(rd_idx_r) < RULE_SLOTS) begin
            rd_idx_r <= rd_idx_r + SCW'(1);
          end
          // drops on its own once the index has run past the last slot
          ev_v_r   <= (int'(rd_idx_r) < RULE_SLOTS);
          ev_idx_r <= rd_idx_r[SW-1:0];
          if (ev_v_r) begin
            if (act_r == ACT_CLEAR) begin
              if (clr_hit) begin
                valid_r[ev_idx_r] <= 1'b0;
                count_r <= count_r - SCW'(1);
              end
            end else begin
              match_r[ev_idx_r] <= m_new;
              if (last_r && en_r && !found_r && hit) begin
                found_r <= 1'b1;
                allow_r <= !m_deny;
              end
            end
            if (int'(ev_idx_r) == RULE_SLOTS - 1) begin
              state_r <= (act_r == ACT_CHECK && !last_r) ? ST_IDLE : ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_act_r     <= act_r;
            out_status_r  <= status_r;
            out_allowed_r <= (act_r == ACT_CHECK) ? allow_r : 1'b0;
            out_total_r   <= TOTAL_W'(count_r);
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_done_action = out_act_r;
  assign out_status      = out_status_r;
  assign out_allowed     = out_allowed_r;
  assign out_rule_total  = out_total_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= RULE_SLOTS)
    else $error("rule count above table size");

  a_count_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) == $countones(valid_r))
    else $error("rule count differs from valid bits");

  a_init_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_action == ACT_INIT) |=> (valid_r == '0 && en_r))
    else $error("init did not clear the table");

  a_disabled_allows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_free && act_r == ACT_CHECK && !en_r) |=> out_allowed)
    else $error("check denied while disabled");
`endif

endmodule
